// ===== rtl/bia_pkg.sv =====
// Shared types, constants and helper functions of the bitmap id allocator.
package bia_pkg;

    // Default pool geometry
    localparam int POOL_SLOTS_DEF = 1024;
    localparam int WORD_BITS_DEF  = 64;

    // Fixed field widths
    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 13;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_FREED     = 3'd2,
        ST_RANGE     = 3'd3,
        ST_DOUBLE    = 3'd4
    } status_t;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Request and result beats
    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] free_id;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    granted_id;
        logic [COUNT_W-1:0] active_count;
        logic [ID_W-1:0]    total_grants;
    } rsp_t;

    // Shared adder control and result
    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t         op;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
    } alu_ctl_t;

    typedef struct packed {
        logic [ID_W-1:0] value;
        logic            ge;     // a >= b, meaningful on subtract
    } alu_res_t;

    // Index of the lowest set bit of a byte (0 when none is set)
    function automatic logic [2:0] lowest8(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/bia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bia_alu.sv =====
// Shared 32-bit add/subtract unit with unsigned compare flag.
module bia_alu (
    input  bia_pkg::alu_ctl_t ctl,
    output bia_pkg::alu_res_t res
);
    import bia_pkg::*;

    logic [ID_W-1:0] b_eff;
    logic [ID_W:0]   sum;

    // Subtract as a + ~b + 1; carry out means no borrow
    always_comb
    begin
        b_eff = (ctl.op == ALU_SUB) ? ~ctl.b : ctl.b;
        sum   = {1'b0, ctl.a} + {1'b0, b_eff} + (ID_W + 1)'(ctl.op == ALU_SUB);
        res.value = sum[ID_W-1:0];
        res.ge    = sum[ID_W];
    end

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the bitmap id allocator: sequencer, counters, register port.
//
//  channel  | dir | handshake             | beat
//  ---------+-----+-----------------------+-------------------------------
//  req      | in  | req_valid / req_stall | req_type, free_id
//  rsp      | out | rsp_valid / rsp_stall | status, granted_id, counts
//  apb      | in  | psel/penable, pready  | id_base at byte address 0
//
// Path from accept until req_stall drops, with the output register free:
// allocate goes through S_SCAN (one RAM read a cycle, up to MAP_WORDS words),
// S_CHUNK, S_BIT and S_DONE; an exhausted pool goes from S_SCAN to S_DONE. Free goes
// through S_RANGE, S_DIV (stepping past up to MAP_WORDS - 1 words), S_FCHK and S_DONE;
// out of range, from S_RANGE to S_DONE. After reset a clearing pass fills the bitmap under req_stall.
// A result waits in the output register while the next request works.
module bitmap_id_allocator #(
    parameter int POOL_SLOTS = bia_pkg::POOL_SLOTS_DEF,
    parameter int WORD_BITS  = bia_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bia_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bia_pkg::rsp_t       rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bia_pkg::*;

    localparam int MAP_WORDS = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLOT_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W     = $clog2(POOL_SLOTS + 1);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NCHUNK    = (WORD_BITS + 7) / 8;
    localparam int CHUNK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_BITS  = NCHUNK * 8;
    localparam int FIND_W    = CHUNK_W + 3;
    localparam int TAIL      = POOL_SLOTS % WORD_BITS;
    localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_WORD =
        (TAIL == 0) ? FULL_WORD : (FULL_WORD >> (WORD_BITS - TAIL));
    localparam logic [WADDR_W-1:0] LAST_W = WADDR_W'(MAP_WORDS - 1);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_CHUNK = 9'b000001000,
        S_BIT   = 9'b000010000,
        S_RANGE = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_FCHK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [WADDR_W-1:0]   clr_reg, clr_next;
    logic [WADDR_W-1:0]   chk_w_reg, chk_w_next;
    logic [WADDR_W-1:0]   issue_w_reg, issue_w_next;
    logic [WADDR_W-1:0]   cnt_reg, cnt_next;
    logic [WADDR_W-1:0]   hint_reg, hint_next;
    logic [CNT_W-1:0]     active_reg, active_next;
    logic [ID_W-1:0]      total_reg, total_next;
    logic [ID_W-1:0]      id_base_reg;
    logic [ID_W-1:0]      slot_reg, slot_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    status_t              status_reg, status_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // RAM port signals
    logic                 ram_wr_en, ram_rd_en;
    logic [WADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

    alu_ctl_t             alu_ctl;
    alu_res_t             alu_res;

    logic                 accept;
    logic [PAD_BITS-1:0]  word_pad;
    logic [7:0]           chunk_flags;
    logic [7:0]           sel_byte;
    logic [FIND_W-1:0]    found;
    logic [BIT_W-1:0]     free_bit;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WADDR_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bia_alu u_alu (
        .ctl (alu_ctl),
        .res (alu_res)
    );

    // Register port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : id_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_base_reg <= 32'd1;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            id_base_reg <= pwdata;
        end
    end

    // Bit search helpers: lowest non-empty byte, then lowest bit in it
    assign word_pad = PAD_BITS'(word_reg);

    always_comb
    begin
        chunk_flags = 8'd0;
        for (int c = 0; c < NCHUNK; c++)
        begin
            chunk_flags[c] = |word_pad[c*8 +: 8];
        end
    end

    assign sel_byte = word_pad[chunk_reg*8 +: 8];
    assign found    = {chunk_reg, lowest8(sel_byte)};
    assign free_bit = BIT_W'(rem_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        chk_w_next     = chk_w_reg;
        issue_w_next   = issue_w_reg;
        cnt_next       = cnt_reg;
        hint_next      = hint_reg;
        active_next    = active_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        rem_next       = rem_reg;
        word_next      = word_reg;
        chunk_next     = chunk_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = chk_w_reg;
        ram_wr_data    = ram_rd_data;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = chk_w_reg;
        alu_ctl.op     = ALU_SUB;
        alu_ctl.a      = slot_reg;
        alu_ctl.b      = 32'(POOL_SLOTS);

        case (state_reg)
            S_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = (clr_reg == LAST_W) ? LAST_WORD : FULL_WORD;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == LAST_W)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                alu_ctl.a = req.free_id;
                alu_ctl.b = id_base_reg;
                if (accept)
                begin
                    if (req.req_type == REQ_ALLOC)
                    begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = hint_reg;
                        chk_w_next   = hint_reg;
                        issue_w_next = (hint_reg == LAST_W) ? '0 : hint_reg + 1'b1;
                        cnt_next     = '0;
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        slot_next  = alu_res.value;
                        state_next = S_RANGE;
                    end
                end
            end
            // One word checked per cycle while the next read is in flight
            S_SCAN:
            begin
                if (|ram_rd_data)
                begin
                    word_next  = ram_rd_data;
                    state_next = S_CHUNK;
                end
                else if (cnt_reg == LAST_W)
                begin
                    status_next = ST_EXHAUSTED;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = issue_w_reg;
                    chk_w_next   = issue_w_reg;
                    issue_w_next = (issue_w_reg == LAST_W) ? '0 : issue_w_reg + 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            S_CHUNK:
            begin
                chunk_next = CHUNK_W'(lowest8(chunk_flags));
                state_next = S_BIT;
            end
            // Claim the bit and form the slot index
            S_BIT:
            begin
                alu_ctl.op  = ALU_ADD;
                alu_ctl.a   = 32'(chk_w_reg) * WORD_BITS;
                alu_ctl.b   = 32'(found);
                slot_next   = alu_res.value;
                ram_wr_en   = 1'b1;
                ram_wr_addr = chk_w_reg;
                ram_wr_data = word_reg & ~(WORD_BITS'(1) << found);
                hint_next   = chk_w_reg;
                active_next = active_reg + 1'b1;
                total_next  = total_reg + 1'b1;
                status_next = ST_GRANTED;
                state_next  = S_DONE;
            end
            S_RANGE:
            begin
                if (alu_res.ge)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    rem_next   = SLOT_W'(slot_reg);
                    chk_w_next = '0;
                    state_next = S_DIV;
                end
            end
            // Reduce the slot to word index and bit by repeated subtraction
            S_DIV:
            begin
                alu_ctl.a = 32'(rem_reg);
                alu_ctl.b = 32'(WORD_BITS);
                if (alu_res.ge)
                begin
                    rem_next   = SLOT_W'(alu_res.value);
                    chk_w_next = chk_w_reg + 1'b1;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = chk_w_reg;
                    state_next  = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (ram_rd_data[free_bit])
                begin
                    status_next = ST_DOUBLE;
                end
                else
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = chk_w_reg;
                    ram_wr_data = ram_rd_data | (WORD_BITS'(1) << free_bit);
                    if (active_reg != '0)
                    begin
                        active_next = active_reg - 1'b1;
                    end
                    status_next = ST_FREED;
                end
                state_next = S_DONE;
            end
            // Hand the result to the output register once it is free
            S_DONE:
            begin
                alu_ctl.op = ALU_ADD;
                alu_ctl.a  = id_base_reg;
                alu_ctl.b  = slot_reg;
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status       = status_reg;
                    rsp_next.granted_id   = (status_reg == ST_GRANTED) ? alu_res.value : '0;
                    rsp_next.active_count = COUNT_W'(active_reg);
                    rsp_next.total_grants = total_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_reg       <= '0;
            hint_reg      <= '0;
            active_reg    <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hint_reg      <= hint_next;
            active_reg    <= active_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        chk_w_reg   <= chk_w_next;
        issue_w_reg <= issue_w_next;
        slot_reg    <= slot_next;
        rem_reg     <= rem_next;
        word_reg    <= word_next;
        chunk_reg   <= chunk_next;
        status_reg  <= status_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_reg) <= POOL_SLOTS)
        else $error("active count above pool size");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall) |=> (!rsp_valid || $past(state_reg == S_DONE)))
        else $error("result beat not loaded from done state");

    a_grant_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIT) |=> (total_reg == $past(total_reg) + 32'd1))
        else $error("grant did not advance total count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(cnt_reg) < MAP_WORDS))
        else $error("scan ran past the last word");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FCHK) |-> (32'(rem_reg) < WORD_BITS))
        else $error("free bit index not reduced below word size");

endmodule

// ===== dv/bitmap_id_allocator_tb.sv =====
// Self-checking testbench of the bitmap id allocator: random traffic, next-fit predictor.
`timescale 1ns / 1ps

module bitmap_id_allocator_tb;
    import bia_pkg::*;

    localparam int POOL      = POOL_SLOTS_DEF;
    localparam int WBITS     = WORD_BITS_DEF;
    localparam int MAP_WORDS = (POOL + WBITS - 1) / WBITS;
    localparam logic [2:0] ADDR_ID_BASE = 3'd0;
    localparam logic [31:0] BASE_MAX = 32'd4294966271;
    localparam int SETTLE_CYCLES = 2 * (MAP_WORDS + 4) + 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_AT       = 3000;
    localparam int HOLD_LEN      = 400;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // allocator shadow state
    logic [WBITS-1:0] free_words [MAP_WORDS];
    int unsigned      scan_hint;
    logic [12:0]      held_slots;
    logic [31:0]      grant_count;
    logic [31:0]      id_base;

    req_t pending_req[$];
    rsp_t expected_rsp[$];
    rsp_t want;
    int   errors = 0;
    int   quiet_cycles = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall pattern
    int stall_pct = 0;
    int stall_span = 0;
    int rx_cycles = 0;
    int hold_left = 0;

    bitmap_id_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // next-fit allocation and release on the shadow bitmap
    function automatic rsp_t alloc_outcome(input req_t r);
        rsp_t        o;
        logic [31:0] slot;
        logic [WBITS-1:0] bits;
        int unsigned w;
        int          b;
        bit          done;
        o.status = ST_EXHAUSTED;
        o.granted_id = '0;
        if (r.req_type == REQ_ALLOC)
        begin
            done = 1'b0;
            for (int i = 0; i < MAP_WORDS && !done; i++)
            begin
                w = (scan_hint + i) % MAP_WORDS;
                bits = free_words[w];
                if (bits != '0)
                begin
                    b = 0;
                    for (int k = WBITS - 1; k >= 0; k--)
                    begin
                        if (bits[k])
                        begin
                            b = k;
                        end
                    end
                    slot = w * WBITS + b;
                    if (slot < POOL)
                    begin
                        free_words[w][b] = 1'b0;
                        scan_hint = w;
                        held_slots = held_slots + 1'b1;
                        grant_count = grant_count + 1;
                        o.granted_id = id_base + slot;
                        o.status = ST_GRANTED;
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // range test wraps modulo 2^32
            slot = r.free_id - id_base;
            if (slot >= POOL)
            begin
                o.status = ST_RANGE;
            end
            else if (free_words[slot / WBITS][slot % WBITS])
            begin
                o.status = ST_DOUBLE;
            end
            else
            begin
                free_words[slot / WBITS][slot % WBITS] = 1'b1;
                if (held_slots != 0)
                begin
                    held_slots = held_slots - 1'b1;
                end
                o.status = ST_FREED;
            end
        end
        o.active_count = held_slots;
        o.total_grants = grant_count;
        return o;
    endfunction

    // id of a slot that is currently held, when one is found quickly
    function automatic logic [31:0] pick_held_id();
        int unsigned slot;
        slot = $urandom_range(0, POOL - 1);
        for (int t = 0; t < 16; t++)
        begin
            slot = $urandom_range(0, POOL - 1);
            if (!free_words[slot / WBITS][slot % WBITS])
            begin
                return id_base + slot;
            end
        end
        return id_base + slot;
    endfunction

    function automatic req_t next_request(input mix_t mix);
        req_t r;
        int   roll;
        int   alloc_pct;
        alloc_pct = (mix == MIX_FILL) ? 97 : (mix == MIX_DRAIN) ? 25 : 50;
        r.free_id = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
        begin
            r.req_type = REQ_ALLOC;
        end
        else
        begin
            r.req_type = REQ_FREE;
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                r.free_id = pick_held_id();
            end
            else if (roll == 7)
            begin
                r.free_id = id_base + $urandom_range(0, POOL - 1);
            end
            else if (roll == 8)
            begin
                case ($urandom_range(0, 3))
                    0: r.free_id = id_base - 1;
                    1: r.free_id = id_base + POOL;
                    2: r.free_id = id_base + POOL - 1;
                    default: r.free_id = id_base;
                endcase
            end
        end
        return r;
    endfunction

    task automatic queue_req(input logic kind, input logic [31:0] id);
        req_t r;
        r.req_type = kind;
        r.free_id = id;
        pending_req.push_back(r);
    endtask

    task automatic run_phase(input mix_t mix, input int count);
        for (int n = 0; n < count; n++)
        begin
            // keep the queue short so frees track the current bitmap
            while (pending_req.size() >= 2)
            begin
                @(posedge clk);
            end
            pending_req.push_back(next_request(mix));
        end
    endtask

    task automatic wait_drained();
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_id_base(input logic [31:0] value);
        wait_drained();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ID_BASE;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        id_base = value;
    endtask

    // request driver: accept, predict, present the next beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(alloc_outcome(req));
            end
            if (!(req_valid && req_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_req.size() != 0)
                begin
                    req <= pending_req.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_AT)
            begin
                hold_left = HOLD_LEN;
            end
            if (stall_span == 0)
            begin
                stall_span = $urandom_range(64, 512);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 40;
                    default: stall_pct = 75;
                endcase
            end
            else
            begin
                stall_span--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result beat: status %0d id %h active %0d total %0d",
                         $time, rsp.status, rsp.granted_id, rsp.active_count,
                         rsp.total_grants);
                errors++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    errors++;
                end
                if (rsp.granted_id !== want.granted_id)
                begin
                    $display("%0t: granted_id expected %h actual %h",
                             $time, want.granted_id, rsp.granted_id);
                    errors++;
                end
                if (rsp.active_count !== want.active_count)
                begin
                    $display("%0t: active_count expected %0d actual %0d",
                             $time, want.active_count, rsp.active_count);
                    errors++;
                end
                if (rsp.total_grants !== want.total_grants)
                begin
                    $display("%0t: total_grants expected %0d actual %0d",
                             $time, want.total_grants, rsp.total_grants);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with work outstanding and no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                || (!req_valid && expected_rsp.size() == 0))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("bitmap_id_allocator_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        // shadow state after reset
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            free_words[w] = '1;
        end
        if (POOL % WBITS != 0)
        begin
            free_words[MAP_WORDS - 1] = (64'd1 << (POOL % WBITS)) - 1;
        end
        scan_hint = 0;
        held_slots = '0;
        grant_count = '0;
        id_base = 32'd1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset base of 1
        queue_req(REQ_ALLOC, 32'h0);
        queue_req(REQ_ALLOC, 32'h0);
        queue_req(REQ_ALLOC, 32'h0);
        queue_req(REQ_FREE, 32'd2);
        queue_req(REQ_FREE, 32'd2);            // already free
        queue_req(REQ_FREE, 32'd0);            // below base, wraps out of range
        queue_req(REQ_FREE, 32'd1 + POOL);     // one past the last slot
        queue_req(REQ_FREE, 32'd0 + POOL);     // last slot, never held
        queue_req(REQ_FREE, 32'hFFFF_FFFF);
        queue_req(REQ_ALLOC, 32'hFFFF_FFFF);   // free_id ignored on allocate
        queue_req(REQ_FREE, 32'd1);
        queue_req(REQ_FREE, 32'd3);
        queue_req(REQ_FREE, 32'd2);
        queue_req(REQ_ALLOC, 32'h0);

        // high base: ids at the top of the 32-bit space
        set_id_base(BASE_MAX);
        queue_req(REQ_FREE, BASE_MAX - 1);
        queue_req(REQ_FREE, 32'hFFFF_FFFF);
        queue_req(REQ_FREE, 32'hFFFF_FFFE);
        queue_req(REQ_FREE, 32'd0);
        queue_req(REQ_ALLOC, 32'h0);
        queue_req(REQ_FREE, BASE_MAX);
        queue_req(REQ_FREE, BASE_MAX);

        // fill until the pool runs dry
        run_phase(MIX_FILL, 1200);

        // middle base, mostly releases with next-fit wrap-around
        set_id_base($urandom_range(2, BASE_MAX - 1));
        run_phase(MIX_DRAIN, 300);

        // lowest base, balanced traffic, then a fill phase
        set_id_base(32'd1);
        run_phase(MIX_EVEN, 200);
        run_phase(MIX_FILL, 100);

        wait_drained();
        if (errors == 0)
        begin
            $display("bitmap_id_allocator_tb OK");
        end
        else
        begin
            $display("bitmap_id_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
